[hdl/sacl_pkg.sv]
package sacl_pkg;

   // Default sizes of the tag store
   localparam int MAX_WAYS_DEF = 4;
   localparam int MAX_SETS_DEF = 64;

   // Field widths
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int CNT_W      = 32;
   localparam int TIME_W     = 48;
   localparam int OFFSET_W   = 4;
   localparam int INDEX_W    = 3;
   localparam int WAYS_W     = 3;
   localparam int PENALTY_W  = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int RSP_PAD_W  = 7;
   localparam int RSP_DATA_W = 1 + 3 * CNT_W + TIME_W + RSP_PAD_W;

   // Register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_LEN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_LEN  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAYS       = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PENALTY    = 2'd3;

   // Register values after reset
   localparam logic [OFFSET_W-1:0]  OFFSET_LEN_RST = 4'd5;
   localparam logic [INDEX_W-1:0]   INDEX_LEN_RST  = 3'd6;
   localparam logic [WAYS_W-1:0]    WAYS_RST       = 3'd1;
   localparam logic [PENALTY_W-1:0] PENALTY_RST    = 10'd50;

   // Request kinds
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP
   } state_type;

   // One way of one set in the tag store
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Update command for the statistics counters
   typedef struct packed {
      logic clear;
      logic count;
      logic hit;
   } stat_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] miss_time;
      logic [CNT_W-1:0]  miss_count;
      logic [CNT_W-1:0]  hit_count;
      logic [CNT_W-1:0]  access_count;
   } stat_type;

endpackage

[hdl/set_assoc_cache_tag_lookup.sv]
// Tag-only set-associative cache lookup with one global round-robin
// replacement pointer. Each request beat carries a byte address and a kind
// in req_tuser: a lookup splits the address into offset, set index and tag
// by the configured bit counts, compares the tag against every valid way in
// use of that set in parallel, and on a miss refills the way named by the
// pointer. Every request beat yields exactly one response beat holding the
// hit flag and the saturating access, hit and miss counts and the 48-bit
// total miss time, all as they stand after this request. In the cycle of
// acceptance the set's row of the tag memory is read into a register, and
// in the next cycle the ways are compared; once the response register is
// free, the row is written back and the result is registered, so the
// write-back lands before the next read. A stalled response holds the
// next request in its compare cycle. A clear request answers with all
// zeros and then sweeps the tag memory, one set per cycle. After reset the
// same sweep runs with req_tready low; configuration writes are taken at
// any time, but only have a defined effect while no request is in flight.
// Stored entries survive configuration changes; an index bit count beyond
// the capacity is clamped, a way count of zero acts as one and one above
// MAX_WAYS acts as MAX_WAYS.
module set_assoc_cache_tag_lookup #(
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sacl_pkg::ADDR_W-1:0]        req_tdata,   // [31:0] address
   input  logic                               req_tuser,   // [0] action: 0 lookup, 1 clear
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hit, [32:1] access_count, [64:33] hit_count, [96:65] miss_count,
   // [144:97] total_miss_time, [151:145] zero
   output logic [sacl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write port
   input  logic                               csr_wr_en,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import sacl_pkg::*;

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);
   // Largest usable index bit count: log2 of MAX_SETS, rounded down.
   localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;

   // Configuration registers
   logic [OFFSET_W-1:0]  offset_len_ff;
   logic [INDEX_W-1:0]   index_len_ff;
   logic [WAYS_W-1:0]    ways_ff;
   logic [PENALTY_W-1:0] penalty_ff;

   // Control and request registers
   state_type            state_ff, state_in;
   logic                 action_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [SET_W-1:0]     set_ff;
   logic [SET_W-1:0]     sweep_ff, sweep_in;
   logic [WAY_W-1:0]     ptr_ff, ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Address split
   logic [3:0]           ib_eff;
   logic [4:0]           tag_shift;
   logic [ADDR_W-1:0]    set_full;
   logic [TAG_W-1:0]     req_tag;
   logic [WCNT_W-1:0]    ways_eff;

   logic                 req_accept;
   logic                 out_free;
   logic                 finish;

   entry_type [MAX_WAYS-1:0] rd_row;
   entry_type [MAX_WAYS-1:0] new_row;
   entry_type [MAX_WAYS-1:0] wr_row;
   logic                 mem_wr_en;
   logic [SET_W-1:0]     mem_wr_addr;
   logic                 hit;
   logic [WAY_W-1:0]     ptr_next;

   stat_cmd_type         stat_cmd;
   stat_type             stats_next;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_len_ff <= OFFSET_LEN_RST;
         index_len_ff  <= INDEX_LEN_RST;
         ways_ff       <= WAYS_RST;
         penalty_ff    <= PENALTY_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_OFFSET_LEN: offset_len_ff <= csr_wr_data[OFFSET_W-1:0];
            CSR_INDEX_LEN:  index_len_ff  <= csr_wr_data[INDEX_W-1:0];
            CSR_WAYS:       ways_ff       <= csr_wr_data[WAYS_W-1:0];
            CSR_PENALTY:    penalty_ff    <= csr_wr_data[PENALTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective settings after clamping to the built capacity.
   always_comb begin
      if (4'(index_len_ff) > 4'(IB_MAX)) begin
         ib_eff = 4'(IB_MAX);
      end else begin
         ib_eff = 4'(index_len_ff);
      end
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
   end

   // The offset is at most 15 and the index at most 7 bits, so the tag
   // shift never reaches the full address width.
   always_comb begin
      tag_shift = 5'(offset_len_ff) + 5'(ib_eff);
      req_tag   = req_tdata >> tag_shift;
      set_full  = (req_tdata >> offset_len_ff) & ((32'd1 << ib_eff) - 32'd1);
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = (action_ff == ACT_CLEAR) ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      finish         = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = set_ff;
      wr_row         = new_row;
      sweep_in       = sweep_ff;
      stat_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOOKUP: begin
            finish = out_free;
            if (out_free) begin
               if (action_ff == ACT_CLEAR) begin
                  stat_cmd.clear = 1'b1;
                  sweep_in       = '0;
               end else begin
                  stat_cmd.count = 1'b1;
                  stat_cmd.hit   = hit;
                  mem_wr_en      = !hit;
               end
            end
         end
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            wr_row      = '0;
            sweep_in    = sweep_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (stat_cmd.clear) begin
         ptr_in = '0;
      end else if (stat_cmd.count && !hit) begin
         ptr_in = ptr_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff <= req_tuser;
         tag_ff    <= req_tag;
         set_ff    <= set_full[SET_W-1:0];
      end
      if (finish) begin
         rsp_data_ff <= {RSP_PAD_W'(0), stats_next.miss_time, stats_next.miss_count,
                         stats_next.hit_count, stats_next.access_count,
                         stat_cmd.count && hit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Datapath units
   // ---------------------------------------------------------------------
   sacl_tag_ram #(
      .MAX_WAYS (MAX_WAYS),
      .MAX_SETS (MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (set_full[SET_W-1:0]),
      .rd_row  (rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_row  (wr_row)
   );

   sacl_way_match #(
      .MAX_WAYS (MAX_WAYS)
   ) u_way_match (
      .row      (rd_row),
      .tag      (tag_ff),
      .ways_eff (ways_eff),
      .ptr      (ptr_ff),
      .hit      (hit),
      .ptr_next (ptr_next),
      .new_row  (new_row)
   );

   sacl_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stat_cmd),
      .penalty    (penalty_ff),
      .stats_next (stats_next)
   );

`ifndef ASSERT_OFF
   // An accepted beat always moves on to the compare cycle.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted request did not enter the compare cycle");

   // A hit must leave the tag memory untouched.
   a_hit_no_write: assert property (@(posedge clock) disable iff (reset)
      (stat_cmd.count && hit) |-> !mem_wr_en)
      else $error("tag memory written on a hit");

   // After a refill the pointer names a way in use.
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (stat_cmd.count && !hit) |=> ({1'b0, ptr_ff} < (WAY_W + 1)'(ways_eff)))
      else $error("replacement pointer beyond the ways in use");

   // A clear answers with an all-zero beat.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      stat_cmd.clear |=> (rsp_tvalid && rsp_tdata == '0))
      else $error("clear response is not all zero");
`endif

endmodule

[hdl/sacl_tag_ram.sv]
module sacl_tag_ram #(
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF
) (
   input  logic                                                clock,
   input  logic                                                rd_en,
   input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] rd_addr,
   output sacl_pkg::entry_type [MAX_WAYS-1:0]                  rd_row,
   input  logic                                                wr_en,
   input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] wr_addr,
   input  sacl_pkg::entry_type [MAX_WAYS-1:0]                  wr_row
);
   import sacl_pkg::*;

   // One row holds every way of a set, so a lookup needs a single read.
   entry_type [MAX_WAYS-1:0] tag_mem [MAX_SETS];
   entry_type [MAX_WAYS-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= tag_mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

[hdl/sacl_way_match.sv]
module sacl_way_match #(
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
   input  sacl_pkg::entry_type [MAX_WAYS-1:0]                  row,
   input  logic [sacl_pkg::TAG_W-1:0]                          tag,
   input  logic [$clog2(MAX_WAYS + 1)-1:0]                     ways_eff,
   input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] ptr,
   output logic                                                hit,
   output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] ptr_next,
   output sacl_pkg::entry_type [MAX_WAYS-1:0]                  new_row
);
   import sacl_pkg::*;

   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   logic [WAY_W-1:0] way;
   logic [WAY_W:0]   way_plus;

   // All ways in use are compared at once.
   always_comb begin
      hit = 1'b0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < int'(ways_eff) && row[w].valid && row[w].tag == tag) begin
            hit = 1'b1;
         end
      end
   end

   // A pointer left beyond the ways in use after a shrink refills way 0.
   always_comb begin
      way      = (int'(ptr) < int'(ways_eff)) ? ptr : '0;
      way_plus = {1'b0, way} + 1'b1;
      ptr_next = (way_plus == (WAY_W + 1)'(ways_eff)) ? '0 : way_plus[WAY_W-1:0];
      new_row  = row;
      new_row[way] = '{valid: 1'b1, tag: tag};
   end

endmodule

[hdl/sacl_stats.sv]
module sacl_stats (
   input  logic                              clock,
   input  logic                              reset,
   input  sacl_pkg::stat_cmd_type            cmd,
   input  logic [sacl_pkg::PENALTY_W-1:0]    penalty,
   output sacl_pkg::stat_type                stats_next
);
   import sacl_pkg::*;

   stat_type          stats_ff;
   stat_type          stats_in;
   logic [TIME_W:0]   time_sum;

   always_comb begin
      stats_in = stats_ff;
      time_sum = {1'b0, stats_ff.miss_time} + (TIME_W + 1)'(penalty);
      if (cmd.clear) begin
         stats_in = '0;
      end else if (cmd.count) begin
         if (stats_ff.access_count != '1) begin
            stats_in.access_count = stats_ff.access_count + 1'b1;
         end
         if (cmd.hit) begin
            if (stats_ff.hit_count != '1) begin
               stats_in.hit_count = stats_ff.hit_count + 1'b1;
            end
         end else begin
            if (stats_ff.miss_count != '1) begin
               stats_in.miss_count = stats_ff.miss_count + 1'b1;
            end
            stats_in.miss_time = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign stats_next = stats_in;

endmodule
